### rtl/core/dap_pkg.sv
// Shared constants, types and sine helpers for the distance attenuation panner.
package dap_pkg;

  // Field widths.
  localparam int unsigned POS_W      = 24;
  localparam int unsigned DIFF_W     = 25;
  localparam int unsigned CLIP_W     = 4;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MASTER_W   = 16;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned HEADING_W  = 16;
  localparam int unsigned PAN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Default number of fraction bits in a coordinate.
  localparam int unsigned COORD_FRAC_BITS_DEF = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_HEADING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME    = 3'd4;

  localparam logic [MASTER_W-1:0]  MASTER_RESET = 16'd19661;
  localparam logic [MASTER_W-1:0]  MASTER_MAX   = 16'd32768;
  localparam logic [HEADING_W-1:0] QUARTER_TURN = 16'h4000;

  // Hearing range squared (36 units, vertical at half weight, doubled sum).
  localparam int unsigned FAR_UNITS_SQ = 2592;
  // Shift that places the squared distance so that its root is Q.17.
  localparam int unsigned DIST_SH_BASE = 33;
  localparam int unsigned DIST_ROOT_W  = 23;
  // Horizontal distance is taken with 12 extra bits before the root.
  localparam int unsigned HYP_SH       = 12;

  // 36.0 in Q.17, and the reciprocal of 9 for the remaining division.
  localparam logic [DIST_ROOT_W-1:0] RSPAN      = 23'd4718592;
  localparam logic [20:0]            RECIP9     = 21'd1864136;
  localparam int unsigned            RECIP9_SH  = 24;
  // Reciprocal of 5 used for the 0.85 pan scale.
  localparam logic [17:0]            RECIP5     = 18'd209716;
  localparam int unsigned            RECIP5_SH  = 20;

  // Products below this limit are under 0.004 in volume.
  localparam logic [48:0] QUIET_LIM = 49'd140737488356;

  localparam int unsigned          QUO_W     = 17;
  localparam logic [15:0]          PAN_FULL  = 16'd32768;
  localparam logic [4:0]           PAN_MUL   = 5'd17;
  localparam logic signed [15:0]   PAN_LIMIT = 16'sd27852;

  // Per-item data that is only carried along the pipeline.
  typedef struct packed {
    logic [CLIP_W-1:0]   clip;
    logic [PITCH_W-1:0]  pitch;
    logic [GAIN_W-1:0]   gain;
    logic [MASTER_W-1:0] master;
  } side_t;

  // Quarter-wave sine table, Q.14, 17 points.
  localparam logic [14:0] QUARTER_SINE [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };

  // Sine over a quarter turn with linear interpolation on the low ten bits.
  function automatic logic [14:0] qsin(input logic [14:0] p);
    logic [4:0]  k;
    logic [9:0]  f;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [24:0] prod;
    k    = {1'b0, p[13:10]};
    f    = p[9:0];
    lo   = QUARTER_SINE[k];
    hi   = QUARTER_SINE[k + 5'd1];
    prod = 25'(hi - lo) * 25'(f);
    if (p[14]) begin
      return 15'd16384;
    end
    return lo + 15'(prod >> 10);
  endfunction

  // Full-turn sine of a binary angle, Q.14.
  function automatic logic signed [15:0] bsin(input logic [15:0] a);
    logic [14:0] pf;
    logic [14:0] pr;
    logic [14:0] mag;
    pf  = {1'b0, a[13:0]};
    pr  = 15'd16384 - pf;
    mag = a[14] ? qsin(pr) : qsin(pf);
    return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

### rtl/core/dap_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module dap_isqrt #(
  parameter int unsigned RootW = 23
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [2*RootW-1:0]   rad_i,
  output logic [RootW-1:0]     root_o
);

  logic [2*RootW-1:0] rad_q  [RootW-1];
  logic [RootW:0]     rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int unsigned Pos = RootW - 1 - k;
    logic [2*RootW-1:0] rad_in;
    logic [RootW:0]     rem_in;
    logic [RootW-1:0]   root_in;
    logic [RootW+2:0]   rem_cat;
    logic [RootW+2:0]   trial;
    logic [RootW+2:0]   rem_sub;
    logic               take;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down the next pair of bits and try the odd subtrahend 4r+1.
    assign rem_cat = {rem_in, rad_in[2*Pos+1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign take    = rem_cat >= trial;
    assign rem_sub = rem_cat - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_sub[RootW:0] : rem_cat[RootW:0];
        root_q[k] <= {root_in[RootW-2:0], take};
      end
    end

    if (k < RootW - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[k] <= rad_in;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

### rtl/core/distance_attenuation_panner_unit.sv
// Top level of the distance attenuation and stereo pan pipeline.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  --------------------------------------
//  request   in         in_valid_i / in_ready_o    clip, source x/y/z, gain, pitch
//  result    out        out_valid_o / out_ready_i  play flag, clip, volume, pan, pitch
//  config    in         cfg_we_i (no back-pressure) register index and write data
//
// One beat is taken per cycle while the pipeline advances, that is while the output
// register is empty or being taken. The pipeline length is set by the
// horizontal square root (COORD_FRAC_BITS + 12 stages) followed by the 17-stage divider.
// Reset clears the valid bits and the configuration registers only; no clearing pass.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall freezes every stage and no beat is lost or repeated.
module distance_attenuation_panner_unit #(
  parameter int unsigned COORD_FRAC_BITS = dap_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [dap_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dap_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dap_pkg::CLIP_W-1:0]           clip_number_i,
  input  logic signed [dap_pkg::POS_W-1:0]     source_x_i,
  input  logic signed [dap_pkg::POS_W-1:0]     source_y_i,
  input  logic signed [dap_pkg::POS_W-1:0]     source_z_i,
  input  logic [dap_pkg::GAIN_W-1:0]           source_gain_i,
  input  logic [dap_pkg::PITCH_W-1:0]          pitch_factor_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 play_now_o,
  output logic [dap_pkg::CLIP_W-1:0]           clip_out_o,
  output logic [dap_pkg::GAIN_W-1:0]           voice_volume_o,
  output logic signed [dap_pkg::PAN_W-1:0]     voice_pan_o,
  output logic [dap_pkg::PITCH_W-1:0]          pitch_out_o
);

  // Stage counts. The pan path (horizontal root and divider) is the longer path, so the volume result
  // waits for the pan result in a short delay line.
  localparam int unsigned HypRootW = COORD_FRAC_BITS + dap_pkg::HYP_SH;
  localparam int unsigned HypRadW  = 2 * HypRootW;
  localparam int unsigned DistRadW = 2 * dap_pkg::DIST_ROOT_W;
  localparam int unsigned DistSh   = dap_pkg::DIST_SH_BASE - 2 * COORD_FRAC_BITS;
  localparam int unsigned QuoW     = dap_pkg::QUO_W;
  localparam int unsigned MagW     = 42;
  localparam int unsigned NumW     = MagW + 7;
  localparam int unsigned DivW     = (NumW > HypRootW + QuoW) ? NumW : HypRootW + QuoW;
  localparam int unsigned Lat      = HypRootW + 26;
  localparam int unsigned TapLen   = HypRootW + 20;
  localparam int unsigned VolLen   = HypRootW - 7;

  localparam logic [50:0] FarLim =
    51'(dap_pkg::FAR_UNITS_SQ) << (2 * COORD_FRAC_BITS);
  localparam logic [49:0] PanMin =
    50'((64'd1 << (2 * COORD_FRAC_BITS)) / 64'd10000);

  typedef struct packed {
    logic                far;
    logic                pen;
    logic                sgn;
    logic [MagW-1:0]     mag;
    dap_pkg::side_t      side;
  } tap_t;

  typedef struct packed {
    logic                          play;
    logic [dap_pkg::GAIN_W-1:0]    vol;
  } vol_t;

  // ---------------------------------------------------------------------------
  // Flow control: one enable for the whole pipeline.
  // ---------------------------------------------------------------------------
  logic           adv;
  logic [Lat-1:0] vld_q;

  assign adv         = ~vld_q[Lat-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to unused indexes are ignored.
  // ---------------------------------------------------------------------------
  logic signed [dap_pkg::POS_W-1:0]  lx_q, ly_q, lz_q;
  logic [dap_pkg::HEADING_W-1:0]     heading_q;
  logic [dap_pkg::MASTER_W-1:0]      master_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q      <= '0;
      ly_q      <= '0;
      lz_q      <= '0;
      heading_q <= '0;
      master_q  <= dap_pkg::MASTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dap_pkg::REG_LISTENER_X:       lx_q      <= cfg_wdata_i;
        dap_pkg::REG_LISTENER_Y:       ly_q      <= cfg_wdata_i;
        dap_pkg::REG_LISTENER_Z:       lz_q      <= cfg_wdata_i;
        dap_pkg::REG_LISTENER_HEADING: heading_q <= cfg_wdata_i[dap_pkg::HEADING_W-1:0];
        dap_pkg::REG_MASTER_VOLUME:    master_q  <= cfg_wdata_i[dap_pkg::MASTER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages: offsets, sine and cosine, products, squares, sums.
  // ---------------------------------------------------------------------------
  logic signed [dap_pkg::DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [15:0]                s1_cos_q, s1_sin_q;
  dap_pkg::side_t                    s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;
  dap_pkg::side_t                    side_in;

  assign side_in.clip   = clip_number_i;
  assign side_in.pitch  = pitch_factor_i;
  assign side_in.gain   = source_gain_i;
  assign side_in.master = (master_q > dap_pkg::MASTER_MAX) ? dap_pkg::MASTER_MAX : master_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dx_q   <= {source_x_i[23], source_x_i} - {lx_q[23], lx_q};
      s1_dy_q   <= {source_y_i[23], source_y_i} - {ly_q[23], ly_q};
      s1_dz_q   <= {source_z_i[23], source_z_i} - {lz_q[23], lz_q};
      // The right vector is (cos h, -sin h).
      s1_cos_q  <= dap_pkg::bsin(heading_q + dap_pkg::QUARTER_TURN);
      s1_sin_q  <= dap_pkg::bsin(heading_q);
      s1_side_q <= side_in;
    end
  end

  logic signed [40:0]  s2_pdx_q, s2_pdz_q;
  logic [24:0]         s2_ax_q, s2_ay_q, s2_az_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pdx_q  <= s1_dx_q * s1_cos_q;
      s2_pdz_q  <= s1_dz_q * s1_sin_q;
      s2_ax_q   <= 25'(s1_dx_q[24] ? -s1_dx_q : s1_dx_q);
      s2_ay_q   <= 25'(s1_dy_q[24] ? -s1_dy_q : s1_dy_q);
      s2_az_q   <= 25'(s1_dz_q[24] ? -s1_dz_q : s1_dz_q);
      s2_side_q <= s1_side_q;
    end
  end

  logic [48:0]         s3_sqx_q, s3_sqy_q, s3_sqz_q;
  logic signed [41:0]  s3_proj_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sqx_q  <= s2_ax_q * s2_ax_q;
      s3_sqy_q  <= s2_ay_q * s2_ay_q;
      s3_sqz_q  <= s2_az_q * s2_az_q;
      s3_proj_q <= 42'(s2_pdx_q) - 42'(s2_pdz_q);
      s3_side_q <= s2_side_q;
    end
  end

  logic [50:0]       s4_sum_q;
  logic [49:0]       s4_h2_q;
  logic [MagW-1:0]   s4_mag_q;
  logic              s4_sgn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Vertical counts at half weight, so the other two axes are doubled.
      s4_sum_q  <= {s3_sqx_q, 1'b0} + 51'(s3_sqy_q) + {s3_sqz_q, 1'b0};
      s4_h2_q   <= 50'(s3_sqx_q) + 50'(s3_sqz_q);
      s4_mag_q  <= MagW'(s3_proj_q[41] ? -s3_proj_q : s3_proj_q);
      s4_sgn_q  <= s3_proj_q[41];
      s4_side_q <= s3_side_q;
    end
  end

  logic                  s5_far_q, s5_pen_q, s5_sgn_q;
  logic [DistRadW-1:0]   s5_radd_q;
  logic [HypRadW-1:0]    s5_radh_q;
  logic [MagW-1:0]       s5_mag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_far_q  <= s4_sum_q > FarLim;
      s5_pen_q  <= s4_h2_q > PanMin;
      // Only in-range values matter here; far sources are dropped later.
      s5_radd_q <= DistRadW'({s4_sum_q, {DistSh{1'b0}}});
      s5_radh_q <= HypRadW'({s4_h2_q, {dap_pkg::HYP_SH{1'b0}}});
      s5_mag_q  <= s4_mag_q;
      s5_sgn_q  <= s4_sgn_q;
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Side delay line: everything that is only needed further down.
  // ---------------------------------------------------------------------------
  tap_t tap_dl_q [TapLen];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tap_dl_q[0] <= '{far: s5_far_q, pen: s5_pen_q, sgn: s5_sgn_q,
                       mag: s5_mag_q, side: s5_side_q};
      for (int i = 1; i < TapLen; i++) begin
        tap_dl_q[i] <= tap_dl_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square roots: full distance in Q.17 and the scaled horizontal length.
  // ---------------------------------------------------------------------------
  logic [dap_pkg::DIST_ROOT_W-1:0] dist_root;
  logic [HypRootW-1:0]             hyp_root;

  dap_isqrt #(
    .RootW (dap_pkg::DIST_ROOT_W)
  ) u_dist_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s5_radd_q),
    .root_o (dist_root)
  );

  dap_isqrt #(
    .RootW (HypRootW)
  ) u_hyp_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s5_radh_q),
    .root_o (hyp_root)
  );

  // ---------------------------------------------------------------------------
  // Volume path: (1 - d/36)^2, then gain * master * attenuation.
  // ---------------------------------------------------------------------------
  logic [22:0] v1_num;
  logic [20:0] v1_m_q;
  logic [41:0] v2_mm_q;
  logic [17:0] v3_r17;
  logic [35:0] v3_sq_q;
  logic [31:0] v3_gm_q;
  logic [16:0] v4_att;
  logic [48:0] v4_prod_q;
  logic        v5_quiet;
  logic [17:0] v5_vol_wide;
  vol_t        v5_res;
  vol_t        vol_dl_q [VolLen];

  // Division by 36 is a shift by two and a multiply by the reciprocal of 9.
  assign v1_num = dap_pkg::RSPAN - dist_root;
  assign v3_r17 = v2_mm_q[41:dap_pkg::RECIP9_SH];
  assign v4_att = v3_sq_q[34:18];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_m_q    <= v1_num[22:2];
      v2_mm_q   <= v1_m_q * dap_pkg::RECIP9;
      v3_sq_q   <= v3_r17 * v3_r17;
      v3_gm_q   <= tap_dl_q[24].side.gain * tap_dl_q[24].side.master;
      v4_prod_q <= v3_gm_q * v4_att;
    end
  end

  assign v5_quiet    = v4_prod_q < dap_pkg::QUIET_LIM;
  assign v5_vol_wide = v4_prod_q[48:31];
  assign v5_res.play = ~tap_dl_q[26].far & ~v5_quiet;
  assign v5_res.vol  = !v5_res.play ? '0 :
                       (|v5_vol_wide[17:16]) ? '1 : v5_vol_wide[15:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vol_dl_q[0] <= v5_res;
      for (int i = 1; i < VolLen; i++) begin
        vol_dl_q[i] <= vol_dl_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pan path: restoring divider, one quotient bit per stage.
  // ---------------------------------------------------------------------------
  logic [DivW-1:0]     dv_rem_q  [QuoW];
  logic [HypRootW-1:0] dv_den_q  [QuoW];
  logic [QuoW-1:0]     dv_quo_q  [1:QuoW];
  logic [2:0]          dv_flag_q [QuoW+1];   // {ov, pen, sgn}
  logic [DivW-1:0]     dv_num;

  assign dv_num = DivW'({tap_dl_q[HypRootW-1].mag, 7'b0});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0]  <= dv_num;
      dv_den_q[0]  <= hyp_root;
      // A quotient of 2^17 or more only needs to saturate.
      dv_flag_q[0] <= {dv_num >= (DivW'(hyp_root) << QuoW),
                       tap_dl_q[HypRootW-1].pen, tap_dl_q[HypRootW-1].sgn};
    end
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_div
    localparam int unsigned Bit = QuoW - 1 - s;
    logic [DivW-1:0] trial;
    logic            ge;
    logic [QuoW-1:0] quo_in;

    assign trial = DivW'(dv_den_q[s]) << Bit;
    assign ge    = dv_rem_q[s] >= trial;

    if (s == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = dv_quo_q[s];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_quo_q[s+1]  <= quo_in | (QuoW'(ge) << Bit);
        dv_flag_q[s+1] <= dv_flag_q[s];
      end
    end

    if (s < QuoW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_rem_q[s+1] <= ge ? dv_rem_q[s] - trial : dv_rem_q[s];
          dv_den_q[s+1] <= dv_den_q[s];
        end
      end
    end
  end

  // Clamp to one, then scale by 17/20: a shift by two and a reciprocal of 5.
  logic [15:0] p1_qc;
  logic [20:0] p1_t;
  logic [17:0] p1_y_q;
  logic [1:0]  p1_flag_q, p2_flag_q;
  logic [35:0] p2_z_q;
  logic [15:0] fin_mag;
  logic signed [dap_pkg::PAN_W-1:0] fin_pan;

  assign p1_qc = (dv_flag_q[QuoW][2] || dv_quo_q[QuoW] > QuoW'(dap_pkg::PAN_FULL)) ?
                 dap_pkg::PAN_FULL : dv_quo_q[QuoW][15:0];
  assign p1_t  = 21'(p1_qc) * 21'(dap_pkg::PAN_MUL);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_y_q    <= p1_t[19:2];
      p1_flag_q <= dv_flag_q[QuoW][1:0];
      p2_z_q    <= p1_y_q * dap_pkg::RECIP5;
      p2_flag_q <= p1_flag_q;
    end
  end

  assign fin_mag = p2_z_q[35:dap_pkg::RECIP5_SH];
  assign fin_pan = (!vol_dl_q[VolLen-1].play || !p2_flag_q[1]) ? '0 :
                   p2_flag_q[0] ? -$signed(fin_mag) : $signed(fin_mag);

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic                               play_q;
  logic [dap_pkg::CLIP_W-1:0]         clip_q;
  logic [dap_pkg::GAIN_W-1:0]         vol_q;
  logic signed [dap_pkg::PAN_W-1:0]   pan_q;
  logic [dap_pkg::PITCH_W-1:0]        pitch_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      play_q  <= vol_dl_q[VolLen-1].play;
      vol_q   <= vol_dl_q[VolLen-1].vol;
      pan_q   <= fin_pan;
      clip_q  <= tap_dl_q[TapLen-1].side.clip;
      pitch_q <= tap_dl_q[TapLen-1].side.pitch;
    end
  end

  assign play_now_o     = play_q;
  assign clip_out_o     = clip_q;
  assign voice_volume_o = vol_q;
  assign voice_pan_o    = pan_q;
  assign pitch_out_o    = pitch_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A held result must stall the whole pipeline, including the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while a result is held");

  // A dropped request carries neither volume nor pan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !play_now_o |-> voice_volume_o == '0 && voice_pan_o == '0)
    else $error("dropped result with volume or pan");

  // The pan never exceeds 0.85 in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> voice_pan_o <= dap_pkg::PAN_LIMIT && voice_pan_o >= -dap_pkg::PAN_LIMIT)
    else $error("pan out of range");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the distance attenuation and stereo pan unit.
`timescale 1ns / 1ps

module tb_top;
  import dap_pkg::*;

  localparam int unsigned FRAC       = COORD_FRAC_BITS_DEF;
  localparam int unsigned LATENCY    = FRAC + 38;
  localparam longint      CYCLE_LIMIT = 600000;

  // One request beat and one result beat.
  typedef struct {
    logic [CLIP_W-1:0]        clip;
    logic signed [POS_W-1:0]  sx;
    logic signed [POS_W-1:0]  sy;
    logic signed [POS_W-1:0]  sz;
    logic [GAIN_W-1:0]        gain;
    logic [PITCH_W-1:0]       pitch;
  } request_t;

  typedef struct {
    logic                     play;
    logic [CLIP_W-1:0]        clip;
    logic [GAIN_W-1:0]        volume;
    logic signed [PAN_W-1:0]  pan;
    logic [PITCH_W-1:0]       pitch;
  } voice_t;

  // A directed row: the request and, where it is obvious, the expected voice.
  typedef struct {
    request_t req;
    bit       typed;
    voice_t   voice;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CLIP_W-1:0] clip_number_i = '0;
  logic signed [POS_W-1:0] source_x_i = '0;
  logic signed [POS_W-1:0] source_y_i = '0;
  logic signed [POS_W-1:0] source_z_i = '0;
  logic [GAIN_W-1:0] source_gain_i = '0;
  logic [PITCH_W-1:0] pitch_factor_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic play_now_o;
  logic [CLIP_W-1:0] clip_out_o;
  logic [GAIN_W-1:0] voice_volume_o;
  logic signed [PAN_W-1:0] voice_pan_o;
  logic [PITCH_W-1:0] pitch_out_o;

  distance_attenuation_panner_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // The testbench's own copy of the listener registers.
  logic signed [POS_W-1:0] lis_x, lis_y, lis_z;
  logic [HEADING_W-1:0]    lis_heading;
  logic [MASTER_W-1:0]     lis_master;

  voice_t expected_voices[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     sending_done = 0;

  // Integer square root, bit by bit, floor of the true root.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint quarter_wave(input int unsigned p);
    int unsigned tbl[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                             12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
    int unsigned k, f;
    if (p >= 16384) return 16384;
    k = p >> 10;
    f = p & 1023;
    return tbl[k] + (((tbl[k + 1] - tbl[k]) * f) >> 10);
  endfunction

  function automatic longint turn_sine(input int unsigned a);
    int unsigned q, p;
    a &= 16'hFFFF;
    q = a >> 14;
    p = a & 16'h3FFF;
    case (q)
      0: return quarter_wave(p);
      1: return quarter_wave(16384 - p);
      2: return -quarter_wave(p);
      default: return -quarter_wave(16384 - p);
    endcase
  endfunction

  // Works out the voice that one request produces under the current registers.
  function automatic voice_t mix_voice(input request_t r);
    voice_t v;
    longint dx, dy, dz, c, sn, proj, pan;
    longint unsigned ax, ay, az, s, d17, r17, att, prod, h2, mag, hl, q, master;
    dx = longint'(r.sx) - longint'(lis_x);
    dy = longint'(r.sy) - longint'(lis_y);
    dz = longint'(r.sz) - longint'(lis_z);
    master = (lis_master > MASTER_MAX) ? MASTER_MAX : lis_master;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    v.play = 0;
    v.clip = r.clip;
    v.volume = 0;
    v.pan = 0;
    v.pitch = r.pitch;
    s = 2 * ax * ax + ay * ay + 2 * az * az;
    // A source beyond the hearing range is dropped.
    if (s > (64'd2592 << (2 * FRAC))) return v;
    d17 = root_floor(s << (33 - 2 * FRAC));
    r17 = ((64'd36 << 17) - d17) / 36;
    att = (r17 * r17) >> 18;
    prod = longint'(r.gain) * master * att;
    // Too quiet to be worth a voice.
    if (prod * 250 < (64'd1 << 45)) return v;
    v.play = 1;
    v.volume = (prod >> 31) > 65535 ? 16'hFFFF : 16'(prod >> 31);
    h2 = ax * ax + az * az;
    pan = 0;
    if (h2 * 10000 > (64'd1 << (2 * FRAC))) begin
      c = turn_sine(lis_heading + 16384);
      sn = turn_sine(lis_heading);
      proj = dx * c - dz * sn;
      mag = proj < 0 ? -proj : proj;
      hl = root_floor(h2 << 12);
      q = (mag << 7) / hl;
      if (q > 32768) q = 32768;
      q = q * 17 / 20;
      pan = proj < 0 ? -longint'(q) : longint'(q);
    end
    v.pan = 16'(pan);
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LISTENER_X:       lis_x = val;
      REG_LISTENER_Y:       lis_y = val;
      REG_LISTENER_Z:       lis_z = val;
      REG_LISTENER_HEADING: lis_heading = val[15:0];
      REG_MASTER_VOLUME:    lis_master = val[15:0];
      default: ;
    endcase
  endtask

  // Sends one request beat. Valid is only lowered when an idle gap follows,
  // so that it never drops and rises within one time step.
  task automatic send_request(input request_t r, input bit typed, input voice_t tv);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    clip_number_i <= r.clip;
    source_x_i <= r.sx;
    source_y_i <= r.sy;
    source_z_i <= r.sz;
    source_gain_i <= r.gain;
    pitch_factor_i <= r.pitch;
    expected_voices.push_back(typed ? tv : mix_voice(r));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_voices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Positions are mostly kept within hearing range of the listener.
  function automatic logic signed [POS_W-1:0] near(input logic signed [POS_W-1:0] base);
    int span;
    span = ($urandom_range(0, 9) == 0) ? 24'sd16000 : 24'sd9216;
    return base + 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic request_t random_request;
    request_t r;
    r.clip = $urandom;
    r.gain = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    r.pitch = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      r.sx = $urandom;
      r.sy = $urandom;
      r.sz = $urandom;
    end else begin
      r.sx = near(lis_x);
      r.sy = near(lis_y);
      r.sz = near(lis_z);
    end
    return r;
  endfunction

  // Result side: random back-pressure and the check against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk_i) begin
    voice_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_voices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = expected_voices.pop_front();
        if (play_now_o !== e.play || clip_out_o !== e.clip || voice_volume_o !== e.volume ||
            voice_pan_o !== e.pan || pitch_out_o !== e.pitch) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected play %0b clip %0d vol %0d pan %0d pitch %0d, got %0b %0d %0d %0d %0d",
                     e.play, e.clip, e.volume, e.pan, e.pitch, play_now_o, clip_out_o,
                     voice_volume_o, voice_pan_o, pitch_out_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!sending_done && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** distance_attenuation_panner_unit: FAILED **");
      $finish;
    end
  end

  directed_row_t rows[$];

  function automatic voice_t dropped(input logic [3:0] c, input logic [15:0] p);
    voice_t v;
    v.play = 0; v.clip = c; v.volume = 0; v.pan = 0; v.pitch = p;
    return v;
  endfunction

  function automatic directed_row_t row(input logic [3:0] c, input int x, input int y, input int z,
                                        input logic [15:0] g, input logic [15:0] p,
                                        input bit typed, input voice_t v);
    directed_row_t d;
    d.req.clip = c; d.req.sx = 24'(x); d.req.sy = 24'(y); d.req.sz = 24'(z);
    d.req.gain = g; d.req.pitch = p; d.typed = typed; d.voice = v;
    return d;
  endfunction

  initial begin
    voice_t none;
    none = dropped(0, 0);
    lis_x = 0; lis_y = 0; lis_z = 0; lis_heading = 0; lis_master = MASTER_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset registers: extremes of every field, far and quiet
    // drops, a source right on the listener, loud sources and every quadrant of pan.
    rows.push_back(row(4'd15, -8388608, -8388608, -8388608, 16'hFFFF, 16'hFFFF, 1,
                       dropped(15, 16'hFFFF)));
    rows.push_back(row(4'd0, 8388607, 8388607, 8388607, 16'hFFFF, 16'h0000, 1, dropped(0, 0)));
    rows.push_back(row(4'd5, 0, 0, 0, 16'd0, 16'h1234, 1, dropped(5, 16'h1234)));
    rows.push_back(row(4'd6, 0, 0, 0, 16'hFFFF, 16'h1000, 0, none));
    rows.push_back(row(4'd7, 0, 0, 0, 16'd16384, 16'h1000, 0, none));
    rows.push_back(row(4'd8, 1, 0, 0, 16'd16384, 16'h0800, 0, none));
    rows.push_back(row(4'd9, 2560, 0, 0, 16'd16384, 16'hAAAA, 0, none));
    rows.push_back(row(4'd10, -2560, 0, 0, 16'd16384, 16'h5555, 0, none));
    rows.push_back(row(4'd11, 0, 0, 2560, 16'd16384, 16'h0001, 0, none));
    rows.push_back(row(4'd12, 0, 0, -2560, 16'd16384, 16'h8000, 0, none));
    rows.push_back(row(4'd13, 0, 9000, 0, 16'd40000, 16'h7FFF, 0, none));
    rows.push_back(row(4'd14, 9216, 0, 0, 16'd16384, 16'h0000, 1, dropped(14, 0)));
    rows.push_back(row(4'd1, 9215, 0, 0, 16'hFFFF, 16'h0000, 0, none));
    rows.push_back(row(4'd2, 6000, 0, 0, 16'd30, 16'h0000, 0, none));
    rows.push_back(row(4'd3, 1000, 300, -700, 16'd20000, 16'h4321, 0, none));
    rows.push_back(row(4'd4, -3000, -200, 1500, 16'd8000, 16'h4321, 0, none));
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].voice);
    drain();

    // Master above one and a heading of a quarter turn.
    write_reg(REG_MASTER_VOLUME, 24'hFFFF);
    write_reg(REG_LISTENER_HEADING, QUARTER_TURN);
    foreach (rows[i]) if (!rows[i].typed) send_request(rows[i].req, 0, none);
    drain();

    // An index beyond the register list must leave every register as it was.
    write_reg(3'd7, 24'hFFFFFF);
    write_reg(3'd5, 24'h123456);
    foreach (rows[i]) if (!rows[i].typed) send_request(rows[i].req, 0, none);
    drain();

    // Random phases, each under a fresh listener, the first two at the extremes.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_LISTENER_X, 24'h800000);
          write_reg(REG_LISTENER_Y, 24'h800000);
          write_reg(REG_LISTENER_Z, 24'h800000);
          write_reg(REG_LISTENER_HEADING, 24'h0);
          write_reg(REG_MASTER_VOLUME, 24'h0);
        end
        1: begin
          write_reg(REG_LISTENER_X, 24'h7FFFFF);
          write_reg(REG_LISTENER_Y, 24'h7FFFFF);
          write_reg(REG_LISTENER_Z, 24'h7FFFFF);
          write_reg(REG_LISTENER_HEADING, 24'hFFFF);
          write_reg(REG_MASTER_VOLUME, 24'h8000);
        end
        default: begin
          write_reg(REG_LISTENER_X, 24'($urandom));
          write_reg(REG_LISTENER_Y, 24'($urandom));
          write_reg(REG_LISTENER_Z, 24'($urandom));
          write_reg(REG_LISTENER_HEADING, 24'($urandom));
          write_reg(REG_MASTER_VOLUME,
                    (phase == 7) ? 24'($urandom) : 24'($urandom_range(0, 32768)));
        end
      endcase
      for (int n = 0; n < 80; n++) send_request(random_request(), 0, none);
      drain();
    end

    sending_done = 1;
    drain();
    if (mismatches == 0) begin
      $display("** distance_attenuation_panner_unit: PASSED **");
    end else begin
      $display("** distance_attenuation_panner_unit: FAILED **");
    end
    $finish;
  end

endmodule
